// ===== rtl/core/fqrrm_pkg.sv =====
package fqrrm_pkg;

    // Fixed sizes of the item fields.
    localparam int NUM_QUEUES = 4;
    localparam int QSEL_W     = 2;
    localparam int ID_W       = 10;

    // Action codes.
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_POP = 1'b1;

    // Queue codes, also the round-robin order.
    localparam logic [QSEL_W-1:0] DIR_WEST  = 2'd0;
    localparam logic [QSEL_W-1:0] DIR_NORTH = 2'd1;
    localparam logic [QSEL_W-1:0] DIR_SOUTH = 2'd2;
    localparam logic [QSEL_W-1:0] DIR_EAST  = 2'd3;

    // One input item.
    typedef struct packed {
        logic              action;
        logic [QSEL_W-1:0] direction;
        logic [ID_W-1:0]   plane_id;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic              got_item;
        logic [ID_W-1:0]   out_id;
        logic [QSEL_W-1:0] out_queue;
        logic              dropped;
        logic              all_empty;
    } out_item_t;

    // Store access requested by the bookkeeping logic.
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [QSEL_W-1:0] queue;
    } mem_cmd_t;

    // Outcome of one item, apart from the identifier read from the store.
    typedef struct packed {
        logic              got_item;
        logic [QSEL_W-1:0] out_queue;
        logic              dropped;
        logic              all_empty;
    } step_info_t;

endpackage

// ===== rtl/core/fqrrm_store.sv =====
module fqrrm_store #(
    parameter int PTR_W = 4
) (
    input  logic                            clk,
    input  fqrrm_pkg::mem_cmd_t             cmd,
    input  logic [PTR_W-1:0]                wr_ptr,
    input  logic [PTR_W-1:0]                rd_ptr,
    input  logic [fqrrm_pkg::ID_W-1:0]      wr_data,
    output logic [fqrrm_pkg::ID_W-1:0]      rd_data
);

    localparam int ADDR_W = fqrrm_pkg::QSEL_W + PTR_W;
    localparam int WORDS  = 1 << ADDR_W;

    logic [fqrrm_pkg::ID_W-1:0] mem [WORDS];
    logic [fqrrm_pkg::ID_W-1:0] rd_data_reg;

    // Each queue owns one contiguous slice of the store.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[{cmd.queue, wr_ptr}] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[{cmd.queue, rd_ptr}];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fqrrm_ctrl.sv =====
module fqrrm_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int PTR_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  fqrrm_pkg::in_item_t       item,
    output fqrrm_pkg::mem_cmd_t       cmd,
    output logic [PTR_W-1:0]          wr_ptr,
    output logic [PTR_W-1:0]          rd_ptr,
    output fqrrm_pkg::step_info_t     info
);

    localparam int NQ = fqrrm_pkg::NUM_QUEUES;

    logic [PTR_W-1:0]              head_reg  [NQ];
    logic [PTR_W-1:0]              head_next [NQ];
    logic [PTR_W-1:0]              tail_reg  [NQ];
    logic [PTR_W-1:0]              tail_next [NQ];
    logic [CNT_W-1:0]              count_reg  [NQ];
    logic [CNT_W-1:0]              count_next [NQ];
    logic [fqrrm_pkg::QSEL_W-1:0]  turn_reg;
    logic [fqrrm_pkg::QSEL_W-1:0]  turn_next;

    logic [NQ-1:0]                 nonempty;
    logic                          found;
    logic [fqrrm_pkg::QSEL_W-1:0]  pick_q;
    logic                          is_pop;
    logic                          full;
    logic                          do_wr;
    logic                          do_rd;

    // Round-robin pick: first non-empty queue from the turn pointer onwards.
    always_comb
    begin
        logic [fqrrm_pkg::QSEL_W-1:0] qi;
        found  = 1'b0;
        pick_q = fqrrm_pkg::DIR_WEST;
        for (int q = 0; q < NQ; q++)
        begin
            nonempty[q] = (count_reg[q] != '0);
        end
        for (int k = 0; k < NQ; k++)
        begin
            qi = turn_reg + fqrrm_pkg::QSEL_W'(k);
            if (!found && nonempty[qi])
            begin
                found  = 1'b1;
                pick_q = qi;
            end
        end
    end

    assign is_pop = (item.action == fqrrm_pkg::ACT_POP);
    assign full   = (count_reg[item.direction] == CNT_W'(QUEUE_DEPTH));
    assign do_wr  = accept && !is_pop && !full;
    assign do_rd  = accept && is_pop && found;

    // Pointer, count and turn updates for the accepted item.
    always_comb
    begin
        for (int q = 0; q < NQ; q++)
        begin
            head_next[q]  = head_reg[q];
            tail_next[q]  = tail_reg[q];
            count_next[q] = count_reg[q];
        end
        turn_next = turn_reg;
        if (do_wr)
        begin
            tail_next[item.direction] =
                (tail_reg[item.direction] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                : tail_reg[item.direction] + 1'b1;
            count_next[item.direction] = count_reg[item.direction] + 1'b1;
        end
        if (do_rd)
        begin
            head_next[pick_q] = (head_reg[pick_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : head_reg[pick_q] + 1'b1;
            count_next[pick_q] = count_reg[pick_q] - 1'b1;
            turn_next = pick_q + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NQ; q++)
            begin
                head_reg[q]  <= '0;
                tail_reg[q]  <= '0;
                count_reg[q] <= '0;
            end
            turn_reg <= fqrrm_pkg::DIR_WEST;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            turn_reg  <= turn_next;
        end
    end

    // Store access for this item.
    always_comb
    begin
        cmd.wr_en = do_wr;
        cmd.rd_en = do_rd;
        cmd.queue = is_pop ? pick_q : item.direction;
    end

    assign wr_ptr = tail_reg[item.direction];
    assign rd_ptr = head_reg[pick_q];

    // Outcome of the item, with emptiness taken after the update.
    always_comb
    begin
        info.got_item  = is_pop && found;
        info.out_queue = (is_pop && found) ? pick_q : fqrrm_pkg::DIR_WEST;
        info.dropped   = !is_pop && full;
        info.all_empty = 1'b1;
        for (int q = 0; q < NQ; q++)
        begin
            if (count_next[q] != '0)
            begin
                info.all_empty = 1'b0;
            end
        end
    end

    // A queue never holds more than its depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[item.direction] <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // A served pop moves the turn to the queue after the one served.
    a_turn_moves: assert property (@(posedge clk) disable iff (!rst_n)
        do_rd |=> turn_reg == $past(pick_q) + 1'b1)
        else $error("turn pointer did not follow the served queue");

    // An enqueue that was dropped leaves that queue's count unchanged.
    a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_pop && full |=> count_reg[$past(item.direction)]
                                      == CNT_W'(QUEUE_DEPTH))
        else $error("dropped enqueue changed the queue count");

endmodule

// ===== rtl/core/four_queue_round_robin_merge.sv =====
// Four-queue round-robin merge.
// Input channel (item_valid, item_stall, item): an item either appends
// plane_id to the queue that direction names (west, north, south, east) or
// pops the next identifier, searching the queues round-robin from the turn
// pointer and skipping empty ones. A full queue drops the identifier and
// flags it in the result.
// Output channel (result_valid, result_stall, result): exactly one result
// per item, in item order.
// The pointers and counts are updated at the accepting edge, where the
// store's registered read port also captures the identifier and the middle
// stage captures the outcome; the result register loads from the middle
// stage when the result register is free or being taken.
// Throughput: one item per cycle while item_stall is low, set by the
// pointer update and the one read and one write port of the store.
// Reset clears all counts and pointers and sets the turn to west; the store
// contents are not cleared and need no clearing pass.
// When the receiver stalls, the result register holds and the stage behind
// it fills; once both are occupied item_stall rises until result_stall
// falls.
module four_queue_round_robin_merge #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  fqrrm_pkg::in_item_t   item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output fqrrm_pkg::out_item_t  result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fqrrm_pkg::mem_cmd_t         cmd;
    fqrrm_pkg::step_info_t       info;
    logic [PTR_W-1:0]            wr_ptr;
    logic [PTR_W-1:0]            rd_ptr;
    logic [fqrrm_pkg::ID_W-1:0]  rd_data;

    logic                        accept;
    logic                        out_load;
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    fqrrm_pkg::step_info_t       s1_info_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    fqrrm_pkg::out_item_t        out_reg;
    fqrrm_pkg::out_item_t        out_next;

    // Flow control: the middle stage moves on whenever the result register
    // is free or being taken.
    assign out_load   = !out_valid_reg || !result_stall;
    assign item_stall = s1_valid_reg && !out_load;
    assign accept     = item_valid && !item_stall;

    fqrrm_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PTR_W       (PTR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (cmd),
        .wr_ptr (wr_ptr),
        .rd_ptr (rd_ptr),
        .info   (info)
    );

    fqrrm_store #(
        .PTR_W (PTR_W)
    ) u_store (
        .clk     (clk),
        .cmd     (cmd),
        .wr_ptr  (wr_ptr),
        .rd_ptr  (rd_ptr),
        .wr_data (item.plane_id),
        .rd_data (rd_data)
    );

    // Middle stage: outcome of the accepted item, aligned with the read data.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_info_reg <= info;
        end
    end

    // Result assembly.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next     = s1_valid_reg;
            out_next.got_item  = s1_info_reg.got_item;
            out_next.out_id    = s1_info_reg.got_item ? rd_data : '0;
            out_next.out_queue = s1_info_reg.out_queue;
            out_next.dropped   = s1_info_reg.dropped;
            out_next.all_empty = s1_info_reg.all_empty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // An accepted item always occupies the middle stage next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost before the middle stage");

    // A blocked middle stage keeps its item.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg && $stable(s1_info_reg))
        else $error("middle stage changed while blocked");

    // An empty pop or an enqueue reports zero identifier and queue.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.got_item |->
            result.out_id == '0 && result.out_queue == fqrrm_pkg::DIR_WEST)
        else $error("non-zero identifier without a popped item");

    // A result never both returns an identifier and reports a drop.
    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dropped |-> !result.got_item)
        else $error("result both dropped and returned an item");

endmodule
